### rtl/isa_ads_pkg.sv
// Shared types, constants and constant functions of the standard atmosphere block.
package isa_ads_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [23:0] TU_SEA    = 24'd9220800;
    localparam logic [23:0] TU_TROPO  = 24'd6932800;
    localparam logic [23:0] TU_SLOPE  = 24'd13;
    localparam logic [19:0] H16_TROPO = 20'd176000;
    localparam logic [22:0] SCALE_NUM = 23'd5;
    localparam logic [23:0] SCALE_DEN = 24'd507328;

    localparam logic [63:0] A_TROPO_FULL = (64'd1013250000 << 30) / 64'd827134575;
    localparam logic [63:0] A_STRAT_FULL = (64'd226320000 << 30) / 64'd621893825;
    localparam logic [30:0] A_TROPO      = A_TROPO_FULL[30:0];
    localparam logic [30:0] A_STRAT      = A_STRAT_FULL[30:0];

    localparam logic [15:0] EXP_NUM     = 16'd42559;
    localparam logic [13:0] EXP_DEN     = 14'd10000;
    localparam logic [30:0] LOG2E_Q30   = 31'd1549082004;
    localparam logic [15:0] SOUND_NUM   = 16'd40187;
    localparam logic [11:0] SOUND_DEN   = 12'd3125;
    localparam logic [30:0] DENSITY_MAX = 31'd1342177279;
    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;

    // Classified item handed from the front to the back.
    typedef struct packed {
        logic        trop;
        logic [23:0] tu;
        logic [23:0] den;
        logic [23:0] xnum;
    } item_t;

    // Q30 value of 2^(-2^-k), built by k repeated floor square roots of 0.5.
    function automatic logic [29:0] exp_root(input int k);
        logic [63:0] r;
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bit_w;
        r = 64'd1 << 29;
        for (int i = 1; i <= k; i++)
        begin
            v     = r << 30;
            res   = '0;
            bit_w = 64'd1 << 62;
            for (int n = 0; n < 32; n++)
            begin
                if (v >= res + bit_w)
                begin
                    v   = v - (res + bit_w);
                    res = (res >> 1) + bit_w;
                end
                else
                begin
                    res = res >> 1;
                end
                bit_w = bit_w >> 2;
            end
            r = res;
        end
        return r[29:0];
    endfunction

endpackage

### rtl/isa_ads_front.sv
// Front stage: clamps the altitude, picks the layer and sets up the divider operands.
module isa_ads_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic signed [20:0]  altitude,
    output logic                q_write,
    output isa_ads_pkg::item_t  q_item,
    input  logic                q_full
);

    logic               valid_reg;
    logic               valid_next;
    isa_ads_pkg::item_t item_reg;
    isa_ads_pkg::item_t item_next;
    logic               take;
    logic [19:0]        h16;
    logic [19:0]        above;
    logic [23:0]        tu_trop;

    assign full    = valid_reg && q_full;
    assign take    = push && !full;
    assign q_write = valid_reg && !q_full;
    assign q_item  = item_reg;

    always_comb
    begin
        h16     = altitude[20] ? 20'd0 : altitude[19:0];
        above   = h16 - isa_ads_pkg::H16_TROPO;
        tu_trop = isa_ads_pkg::TU_SEA - {4'd0, h16} * isa_ads_pkg::TU_SLOPE;
        item_next.trop = (h16 <= isa_ads_pkg::H16_TROPO);
        if (item_next.trop)
        begin
            item_next.tu   = tu_trop;
            item_next.den  = tu_trop;
            item_next.xnum = isa_ads_pkg::TU_SEA;
        end
        else
        begin
            item_next.tu   = isa_ads_pkg::TU_TROPO;
            item_next.den  = isa_ads_pkg::SCALE_DEN;
            item_next.xnum = {1'b0, {3'd0, above} * isa_ads_pkg::SCALE_NUM};
        end
    end

    always_comb
    begin
        if (take)
            valid_next = 1'b1;
        else if (q_write)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= item_next;
    end

endmodule

### rtl/isa_ads_queue.sv
// Short queue of classified items between the front and the back.
module isa_ads_queue #(
    parameter int DEPTH = isa_ads_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  isa_ads_pkg::item_t  wr_item,
    output logic                is_full,
    input  logic                rd_en,
    output isa_ads_pkg::item_t  rd_item,
    output logic                rd_valid
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    isa_ads_pkg::item_t mem_reg [DEPTH];
    logic [PW-1:0]      wr_ptr_reg;
    logic [PW-1:0]      rd_ptr_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;

    assign is_full  = (count_reg == CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !(rd_en && rd_valid))
            count_next = count_reg + 1'b1;
        else if (!wr_en && rd_en && rd_valid)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (wr_en)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (rd_en && rd_valid)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_item;
    end

endmodule

### rtl/isa_ads_back.sv
// Back pipeline: divider, log2, exponent scaling, 2^-E, density and speed of sound.
module isa_ads_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  isa_ads_pkg::item_t  q_item,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_take,
    output logic [30:0]         density,
    output logic [24:0]         sound_speed,
    output logic                status
);

    localparam int DIV_FIRST = 1;
    localparam int DIV_N     = 34;
    localparam int LOG_FIRST = DIV_FIRST + DIV_N;
    localparam int LOG_N     = 30;
    localparam int MUL_STAGE = LOG_FIRST + LOG_N;
    localparam int D10_FIRST = MUL_STAGE + 1;
    localparam int D10_N     = 9;
    localparam int EXP_FIRST = D10_FIRST + D10_N;
    localparam int EXP_N     = 30;
    localparam int FIN_STAGE = EXP_FIRST + EXP_N;
    localparam int DEPTH     = FIN_STAGE;
    localparam int SMUL      = 1;
    localparam int SD_FIRST  = 2;
    localparam int SD_N      = 13;
    localparam int SQ_FIRST  = SD_FIRST + SD_N;
    localparam int SQ_N      = 25;

    typedef struct packed {
        logic        trop;
        logic [23:0] tu;
        logic [23:0] den;
        logic [3:0]  xlo;
        logic [23:0] rem;
        logic [33:0] quo;
        logic [30:0] lx;
        logic [29:0] ly;
        logic [45:0] pdiv;
        logic [13:0] r10k;
        logic [35:0] q10k;
        logic [33:0] ex;
        logic [30:0] m;
        logic [38:0] snum;
        logic [11:0] rsnd;
        logic [51:0] qsnd;
        logic [25:0] sqrem;
        logic [24:0] sqroot;
        logic [30:0] dens;
        logic        status;
    } stage_t;

    stage_t           st_reg  [1:DEPTH];
    stage_t           st_next [1:DEPTH];
    stage_t           st_in0;
    logic [DEPTH:1]   valid_reg;
    logic             adv;

    // The whole pipeline moves unless a finished item waits at the output.
    assign adv       = !valid_reg[DEPTH] || out_take;
    assign q_pop     = adv && q_valid;
    assign out_valid = valid_reg[DEPTH];

    assign density     = st_reg[DEPTH].dens;
    assign sound_speed = st_reg[DEPTH].sqroot;
    assign status      = st_reg[DEPTH].status;

    always_comb
    begin
        st_in0      = '0;
        st_in0.trop = q_item.trop;
        st_in0.tu   = q_item.tu;
        st_in0.den  = q_item.den;
        st_in0.xlo  = q_item.xnum[3:0];
        st_in0.rem  = {4'd0, q_item.xnum[23:4]};
    end

    for (genvar j = 1; j <= DEPTH; j++)
    begin : g_stage
        localparam bit IN_DIV = (j >= DIV_FIRST) && (j < DIV_FIRST + DIV_N);
        localparam bit IN_LOG = (j >= LOG_FIRST) && (j < LOG_FIRST + LOG_N);
        localparam bit IN_D10 = (j >= D10_FIRST) && (j < D10_FIRST + D10_N);
        localparam bit IN_EXP = (j >= EXP_FIRST) && (j < EXP_FIRST + EXP_N);
        localparam bit IN_SD  = (j >= SD_FIRST) && (j < SD_FIRST + SD_N);
        localparam bit IN_SQ  = (j >= SQ_FIRST) && (j < SQ_FIRST + SQ_N);
        localparam int DIV_I  = IN_DIV ? (DIV_FIRST + DIV_N - 1 - j) : 0;
        localparam bit DIV_HB = IN_DIV && (DIV_I >= 30);
        localparam int DIV_XB = DIV_HB ? (DIV_I - 30) : 0;
        localparam int LOG_YB = IN_LOG ? (LOG_N - 1 - (j - LOG_FIRST)) : 0;
        localparam int D10_B  = IN_D10 ? (35 - 4 * (j - D10_FIRST)) : 3;
        localparam int SD_B   = IN_SD ? (51 - 4 * (j - SD_FIRST)) : 3;
        localparam int SQ_I   = IN_SQ ? (SQ_N - 1 - (j - SQ_FIRST)) : 0;
        localparam int EXP_FB = IN_EXP ? (EXP_N - 1 - (j - EXP_FIRST)) : 0;
        localparam int EXP_K  = IN_EXP ? (j - EXP_FIRST + 1) : 1;
        localparam logic [29:0] RK = isa_ads_pkg::exp_root(EXP_K);

        stage_t src;

        if (j == 1)
        begin : g_first
            assign src = st_in0;
        end
        else
        begin : g_next
            assign src = st_reg[j-1];
        end

        always_comb
        begin
            stage_t      s;
            logic [24:0] dr;
            logic [30:0] lx_in;
            logic [61:0] lsq;
            logic [33:0] ma;
            logic [30:0] mb;
            logic [64:0] mp;
            logic [13:0] r10;
            logic [14:0] t10;
            logic [11:0] rs;
            logic [12:0] ts;
            logic [27:0] tq;
            logic [27:0] trial;
            logic [30:0] m_in;
            logic [60:0] ep;
            logic [30:0] mshift;
            logic [61:0] fp;
            logic [31:0] fd;
            int          p;

            s = src;

            // Shared restoring divider: one quotient bit per stage.
            if (IN_DIV)
            begin
                dr = {s.rem, DIV_HB ? s.xlo[DIV_XB] : 1'b0};
                if (dr >= {1'b0, s.den})
                begin
                    s.rem        = 24'(dr - {1'b0, s.den});
                    s.quo[DIV_I] = 1'b1;
                end
                else
                begin
                    s.rem        = dr[23:0];
                    s.quo[DIV_I] = 1'b0;
                end
            end

            // log2 by repeated squaring, one fraction bit per stage.
            if (IN_LOG)
            begin
                lx_in = (j == LOG_FIRST) ? s.quo[30:0] : s.lx;
                lsq   = 62'(lx_in) * 62'(lx_in);
                if (lsq[61])
                begin
                    s.lx         = lsq[61:31];
                    s.ly[LOG_YB] = 1'b1;
                end
                else
                begin
                    s.lx         = lsq[60:30];
                    s.ly[LOG_YB] = 1'b0;
                end
            end

            // One multiplier serves both layers: power-law exponent or log2(e).
            if (j == MUL_STAGE)
            begin
                ma     = s.trop ? {4'd0, s.ly} : s.quo;
                mb     = s.trop ? {15'd0, isa_ads_pkg::EXP_NUM} : isa_ads_pkg::LOG2E_Q30;
                mp     = 65'(ma) * 65'(mb);
                s.pdiv = mp[45:0];
                if (!s.trop)
                    s.ex = mp[63:30];
            end

            if (IN_D10)
            begin
                r10 = (j == D10_FIRST) ? {4'd0, s.pdiv[45:36]} : s.r10k;
                for (int b = 0; b < 4; b++)
                begin
                    p   = D10_B - b;
                    t10 = {r10, s.pdiv[p]};
                    if (t10 >= {1'b0, isa_ads_pkg::EXP_DEN})
                    begin
                        r10       = 14'(t10 - {1'b0, isa_ads_pkg::EXP_DEN});
                        s.q10k[p] = 1'b1;
                    end
                    else
                    begin
                        r10       = t10[13:0];
                        s.q10k[p] = 1'b0;
                    end
                end
                s.r10k = r10;
                if ((j == D10_FIRST + D10_N - 1) && s.trop)
                    s.ex = s.q10k[33:0];
            end

            // 2^-f as a product of the roots picked by the fraction bits.
            if (IN_EXP)
            begin
                m_in = (j == EXP_FIRST) ? isa_ads_pkg::ONE_Q30 : s.m;
                ep   = 61'(m_in) * 61'(RK);
                s.m  = s.ex[EXP_FB] ? ep[60:30] : m_in;
            end

            if (j == FIN_STAGE)
            begin
                mshift   = s.m >> s.ex[33:30];
                fp       = 62'(mshift) * 62'(s.trop ? isa_ads_pkg::A_TROPO
                                                    : isa_ads_pkg::A_STRAT);
                fd       = fp[61:30];
                s.dens   = (fd > {1'b0, isa_ads_pkg::DENSITY_MAX})
                           ? isa_ads_pkg::DENSITY_MAX : fd[30:0];
                s.status = (fd == 32'd0);
            end

            if (j == SMUL)
                s.snum = 39'(s.tu) * 39'(isa_ads_pkg::SOUND_NUM);

            // Division by 3125 of the scaled product, four bits per stage.
            if (IN_SD)
            begin
                rs = (j == SD_FIRST) ? {3'd0, s.snum[38:30]} : s.rsnd;
                for (int b = 0; b < 4; b++)
                begin
                    p  = SD_B - b;
                    ts = {rs, (p >= 22) ? s.snum[(p >= 22) ? (p - 22) : 0] : 1'b0};
                    if (ts >= {1'b0, isa_ads_pkg::SOUND_DEN})
                    begin
                        rs        = 12'(ts - {1'b0, isa_ads_pkg::SOUND_DEN});
                        s.qsnd[p] = 1'b1;
                    end
                    else
                    begin
                        rs        = ts[11:0];
                        s.qsnd[p] = 1'b0;
                    end
                end
                s.rsnd = rs;
            end

            // Digit-by-digit square root, one result bit per stage.
            if (IN_SQ)
            begin
                tq    = {(j == SQ_FIRST) ? 26'd0 : s.sqrem, s.qsnd[2*SQ_I+1 -: 2]};
                trial = {1'b0, (j == SQ_FIRST) ? 25'd0 : s.sqroot, 2'b01};
                if (tq >= trial)
                begin
                    s.sqrem  = 26'(tq - trial);
                    s.sqroot = {((j == SQ_FIRST) ? 24'd0 : s.sqroot[23:0]), 1'b1};
                end
                else
                begin
                    s.sqrem  = tq[25:0];
                    s.sqroot = {((j == SQ_FIRST) ? 24'd0 : s.sqroot[23:0]), 1'b0};
                end
            end

            st_next[j] = s;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                st_reg[j] <= st_next[j];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[DEPTH-1:1], q_valid};
    end

endmodule

### rtl/isa_atmosphere_density_sound_speed.sv
// Top level: two-layer standard atmosphere, altitude in, density and speed of sound out.
//
// Each item is one altitude in 1/16 m; negative values count as sea level. The block
// takes one item per clock and gives one result per clock while results are taken.
// An item is held in the front register, then waits in the queue and then moves down
// the 105 back pipeline stages. The back pipeline is made of 34 divider steps, 30 log2
// squaring steps, a shared multiply, 9 stages of division by 10000, 30 steps of the
// fractional power of two and a final density multiply; the speed of sound runs
// alongside in the same stages. When the oldest result is not taken the back pipeline
// holds, and the queue and front register still take up to three more items.
module isa_atmosphere_density_sound_speed #(
    parameter int QUEUE_DEPTH = isa_ads_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic signed [20:0]  altitude,
    output logic                empty,
    input  logic                pop,
    output logic [30:0]         density,
    output logic [24:0]         sound_speed,
    output logic                status
);

    logic               q_write;
    logic               q_full;
    logic               q_pop;
    logic               q_valid;
    logic               out_valid;
    isa_ads_pkg::item_t wr_item;
    isa_ads_pkg::item_t rd_item;

    assign empty = !out_valid;

    isa_ads_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .altitude (altitude),
        .q_write  (q_write),
        .q_item   (wr_item),
        .q_full   (q_full)
    );

    isa_ads_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_write),
        .wr_item  (wr_item),
        .is_full  (q_full),
        .rd_en    (q_pop),
        .rd_item  (rd_item),
        .rd_valid (q_valid)
    );

    isa_ads_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (rd_item),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_take    (pop),
        .density     (density),
        .sound_speed (sound_speed),
        .status      (status)
    );

endmodule

### rtl/isa_ads_checker.sv
// Port-level checker for the standard atmosphere block and its bind.
module isa_ads_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                push,
    input logic                full,
    input logic signed [20:0]  altitude,
    input logic                empty,
    input logic                pop,
    input logic [30:0]         density,
    input logic [24:0]         sound_speed,
    input logic                status
);

    // The status flag marks exactly a density of zero.
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (status == (density == 31'd0)))
        else $error("status does not match a zero density");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(density) && $stable(sound_speed)
                              && $stable(status)))
        else $error("waiting item changed or vanished");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (density <= isa_ads_pkg::DENSITY_MAX && sound_speed <= 25'd22347776))
        else $error("result out of range");

    // Temperature never drops below the stratosphere value, so neither does the speed.
    a_speed_floor: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (sound_speed >= 25'd19000000))
        else $error("speed of sound below the stratosphere value");

endmodule

bind isa_atmosphere_density_sound_speed isa_ads_checker u_isa_ads_checker (.*);
